// File: design/reorder_receive_window_defines.svh
`ifndef REORDER_RECEIVE_WINDOW_DEFINES_SVH
`define REORDER_RECEIVE_WINDOW_DEFINES_SVH

// same-cycle implication
`define RRW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RRW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/rrw_pkg.sv
package rrw_pkg;

   localparam int DEF_WINDOW       = 8;
   localparam int DEF_PAYLOAD_BITS = 64;

   localparam logic [1:0] MODE_DATA = 2'd0;
   localparam logic [1:0] MODE_TICK = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   localparam logic KIND_MSG = 1'b0;
   localparam logic KIND_ACK = 1'b1;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  seq;
      logic [63:0] payload;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  number;
      logic [63:0] data;
      logic [3:0]  free_window;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic wr;
      logic clr;
   } hold_op_type;

endpackage

// File: design/rrw_hold_store.sv
module rrw_hold_store #(
   parameter int WINDOW       = rrw_pkg::DEF_WINDOW,
   parameter int PAYLOAD_BITS = rrw_pkg::DEF_PAYLOAD_BITS,
   localparam int IDX_W       = $clog2(WINDOW)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rrw_pkg::hold_op_type    op,
   input  logic [IDX_W-1:0]        wr_idx,
   input  logic [PAYLOAD_BITS-1:0] wr_data,
   input  logic [IDX_W-1:0]        clr_idx,
   input  logic [IDX_W-1:0]        rd_idx,
   output logic [PAYLOAD_BITS-1:0] rd_data,
   output logic [WINDOW-1:0]       valid
);

   logic [PAYLOAD_BITS-1:0] hold_data_ff [WINDOW];
   logic [PAYLOAD_BITS-1:0] rd_data_ff;
   logic [WINDOW-1:0]       valid_ff;
   logic [WINDOW-1:0]       valid_in;

   always_ff @(posedge clock) begin
      if (op.wr) begin
         hold_data_ff[wr_idx] <= wr_data;
      end
      rd_data_ff <= hold_data_ff[rd_idx];
   end

   always_comb begin
      valid_in = valid_ff;
      if (op.wr) begin
         valid_in[wr_idx] = 1'b1;
      end
      if (op.clr) begin
         valid_in[clr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_data = rd_data_ff;
   assign valid   = valid_ff;

endmodule

// File: design/reorder_receive_window.sv
// channel   direction  word type          handshake
// req       in         rrw_pkg::req_type  req_valid / req_ready
// rsp       out        rrw_pkg::rsp_type  rsp_valid / rsp_ready
//
// Each item is accepted in IDLE, then evaluated against the window in EVAL.
// An in-order word then flushes each held word (slot read in LOOK, then
// deliver in DELIV) and a closing ack; the registered slot memory read sets
// that order. Reset clears the slot valid bits at once; no sweep.
// A stalled rsp side holds any step that emits a word until the output register frees.
`include "reorder_receive_window_defines.svh"

module reorder_receive_window #(
   parameter int WINDOW       = rrw_pkg::DEF_WINDOW,
   parameter int PAYLOAD_BITS = rrw_pkg::DEF_PAYLOAD_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rrw_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rrw_pkg::rsp_type rsp_word
);

   localparam int IDX_W   = $clog2(WINDOW);
   localparam int OCC_MAX = 4 * WINDOW - 1;
   localparam int OCC_W   = $clog2(OCC_MAX + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EVAL  = 2'd1;
   localparam logic [1:0] ST_LOOK  = 2'd2;
   localparam logic [1:0] ST_DELIV = 2'd3;

   logic [1:0]       state_ff, state_in;
   rrw_pkg::req_type item_ff, item_in;
   logic [7:0]       last_acked_ff, last_acked_in;
   logic [IDX_W-1:0] base_ff, base_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             full_ff, full_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rrw_pkg::rsp_type rsp_ff, rsp_in;

   rrw_pkg::hold_op_type    hold_op;
   logic [PAYLOAD_BITS-1:0] hold_rd_data;
   logic [WINDOW-1:0]       hold_valid;
   logic [IDX_W-1:0]        slot_idx;

   logic             out_free;
   logic             push;
   logic [7:0]       expect_seq;
   logic [7:0]       offset;
   logic             in_window;
   logic [IDX_W:0]   slot_sum;
   logic [IDX_W-1:0] base_next;
   logic [OCC_W-1:0] occ_inc;
   logic             full_cond;
   logic [3:0]       free_cur;
   logic [3:0]       free_inc;

   rrw_hold_store #(
      .WINDOW      (WINDOW),
      .PAYLOAD_BITS(PAYLOAD_BITS)
   ) u_hold (
      .clock  (clock),
      .reset  (reset),
      .op     (hold_op),
      .wr_idx (slot_idx),
      .wr_data(item_ff.payload[PAYLOAD_BITS-1:0]),
      .clr_idx(base_ff),
      .rd_idx (base_ff),
      .rd_data(hold_rd_data),
      .valid  (hold_valid)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign expect_seq = last_acked_ff + 8'd1;
   assign offset     = item_ff.seq - expect_seq;
   assign in_window  = offset < 8'(WINDOW);
   assign slot_sum   = {1'b0, base_ff} + {1'b0, offset[IDX_W-1:0]};
   assign slot_idx   = (slot_sum >= (IDX_W+1)'(WINDOW)) ?
                       IDX_W'(slot_sum - (IDX_W+1)'(WINDOW)) : slot_sum[IDX_W-1:0];
   assign base_next  = (base_ff == IDX_W'(WINDOW - 1)) ? '0 : base_ff + IDX_W'(1);
   assign occ_inc    = (occ_ff < OCC_W'(OCC_MAX)) ? occ_ff + OCC_W'(1) : occ_ff;
   assign full_cond  = occ_ff >= OCC_W'(WINDOW);
   assign free_cur   = full_cond ? 4'd0 : 4'(OCC_W'(WINDOW) - occ_ff);
   assign free_inc   = (occ_inc >= OCC_W'(WINDOW)) ? 4'd0 : 4'(OCC_W'(WINDOW) - occ_inc);

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      last_acked_in = last_acked_ff;
      base_in       = base_ff;
      occ_in        = occ_ff;
      full_in       = full_ff;
      hold_op       = '0;
      push          = 1'b0;
      rsp_in        = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_word;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            case (item_ff.mode)
               rrw_pkg::MODE_DATA: begin
                  if (!in_window) begin
                     if (out_free) begin
                        push     = 1'b1;
                        rsp_in   = '{rrw_pkg::KIND_ACK, last_acked_ff, 64'd0, free_cur, 1'b1};
                        state_in = ST_IDLE;
                     end
                  end else if (offset != 8'd0) begin
                     hold_op.wr = !hold_valid[slot_idx];
                     state_in   = ST_IDLE;
                  end else if (out_free) begin
                     push          = 1'b1;
                     rsp_in        = '{rrw_pkg::KIND_MSG, item_ff.seq,
                                       64'(item_ff.payload[PAYLOAD_BITS-1:0]),
                                       free_inc, 1'b0};
                     occ_in        = occ_inc;
                     last_acked_in = item_ff.seq;
                     base_in       = base_next;
                     state_in      = ST_LOOK;
                  end
               end
               rrw_pkg::MODE_TICK: begin
                  if (full_ff && !full_cond) begin
                     if (out_free) begin
                        push     = 1'b1;
                        rsp_in   = '{rrw_pkg::KIND_ACK, last_acked_ff, 64'd0, free_cur, 1'b1};
                        full_in  = 1'b0;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               rrw_pkg::MODE_READ: begin
                  if (occ_ff != '0) begin
                     occ_in = occ_ff - OCC_W'(1);
                  end
                  state_in = ST_IDLE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_LOOK: begin
            if (hold_valid[base_ff]) begin
               state_in = ST_DELIV;
            end else if (out_free) begin
               push     = 1'b1;
               rsp_in   = '{rrw_pkg::KIND_ACK, last_acked_ff, 64'd0, free_cur, 1'b1};
               full_in  = full_cond;
               state_in = ST_IDLE;
            end
         end
         ST_DELIV: begin
            if (out_free) begin
               push          = 1'b1;
               rsp_in        = '{rrw_pkg::KIND_MSG, expect_seq, 64'(hold_rd_data),
                                 free_inc, 1'b0};
               hold_op.clr   = 1'b1;
               occ_in        = occ_inc;
               last_acked_in = expect_seq;
               base_in       = base_next;
               state_in      = ST_LOOK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = push ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_acked_ff <= '0;
         base_ff       <= '0;
         occ_ff        <= '0;
         full_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_acked_ff <= last_acked_in;
         base_ff       <= base_in;
         occ_ff        <= occ_in;
         full_ff       <= full_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `RRW_ASSERT_IMP(a_ack_word, clock, reset,
      rsp_valid_ff && rsp_ff.kind == rrw_pkg::KIND_ACK,
      rsp_ff.data == '0 && rsp_ff.last, "ack word carries data or lacks last")
   `RRW_ASSERT_IMP(a_deliv_held, clock, reset, state_ff == ST_DELIV,
      hold_valid[base_ff], "flush delivers an empty slot")
   `RRW_ASSERT_IMP(a_occ_bound, clock, reset, 1'b1, occ_ff <= OCC_W'(OCC_MAX),
      "occupancy above its ceiling")
   `RRW_ASSERT_NEXT(a_accept_eval, clock, reset, req_valid && req_ready,
      state_ff == ST_EVAL, "accepted word not evaluated")

endmodule
